// ===== rtl/svce_pkg.sv =====
// ============================================================================
// svce_pkg - shared definitions for the scalar/vector execute block
// Opcodes, branch condition codes, flag bit positions, sizes and word types.
// ============================================================================
package svce_pkg;

    localparam logic [7:0] OP_ADD    = 8'd0;
    localparam logic [7:0] OP_SUB    = 8'd1;
    localparam logic [7:0] OP_ADDI   = 8'd2;
    localparam logic [7:0] OP_SUBI   = 8'd3;
    localparam logic [7:0] OP_MUL    = 8'd4;
    localparam logic [7:0] OP_MULI   = 8'd5;
    localparam logic [7:0] OP_DIV    = 8'd6;
    localparam logic [7:0] OP_DIVI   = 8'd7;
    localparam logic [7:0] OP_LDR    = 8'd8;
    localparam logic [7:0] OP_LDI    = 8'd9;
    localparam logic [7:0] OP_STR    = 8'd10;
    localparam logic [7:0] OP_STI    = 8'd11;
    localparam logic [7:0] OP_MOVI   = 8'd12;
    localparam logic [7:0] OP_MOV    = 8'd13;
    localparam logic [7:0] OP_VBCAST = 8'd14;
    localparam logic [7:0] OP_VADD   = 8'd15;
    localparam logic [7:0] OP_VSUB   = 8'd16;
    localparam logic [7:0] OP_VMUL   = 8'd17;
    localparam logic [7:0] OP_VEXT   = 8'd18;
    localparam logic [7:0] OP_HALT   = 8'd19;
    localparam logic [7:0] OP_BR_LO  = 8'd20;
    localparam logic [7:0] OP_BR_HI  = 8'd34;

    localparam logic [3:0] CC_EQ = 4'd0;
    localparam logic [3:0] CC_NE = 4'd1;
    localparam logic [3:0] CC_CS = 4'd2;
    localparam logic [3:0] CC_CC = 4'd3;
    localparam logic [3:0] CC_MI = 4'd4;
    localparam logic [3:0] CC_PL = 4'd5;
    localparam logic [3:0] CC_VS = 4'd6;
    localparam logic [3:0] CC_VC = 4'd7;
    localparam logic [3:0] CC_HI = 4'd8;
    localparam logic [3:0] CC_LS = 4'd9;
    localparam logic [3:0] CC_GE = 4'd10;
    localparam logic [3:0] CC_LT = 4'd11;
    localparam logic [3:0] CC_GT = 4'd12;
    localparam logic [3:0] CC_LE = 4'd13;

    localparam int FLAG_Z = 0;
    localparam int FLAG_N = 1;
    localparam int FLAG_C = 2;
    localparam int FLAG_V = 3;

    localparam int LANES      = 4;
    localparam int LANE_W     = 32;
    localparam int SCALAR_NUM = 256;
    localparam int VECTOR_NUM = 32;

    typedef logic [LANE_W-1:0]       word_t;
    typedef logic [LANES*LANE_W-1:0] vec_t;

endpackage

// ===== rtl/scalar_vector_cpu_execute.sv =====
// ============================================================================
// scalar_vector_cpu_execute - multicycle execute stage
// Runs one instruction at a time against scalar and vector register files,
// a data memory and the ZNCV flags; ALU ops share one adder/multiplier.
// ============================================================================
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, cmd, dest_byte,              | into block
//          | first_src_byte, second_src_byte                  |
//  out     | out_valid, out_stall, next_pc, halted,           | out of block
//          | div_by_zero, unknown_op, flag_*, written_value   |
//
//  Most instructions pass three register file read slots, one execute state
//  and a writeback. Vector add, sub and mul add a lane state that works one
//  lane at a time. div and divi run 32 restoring steps on the shared adder;
//  ldi adds a memory read and wait, sti a memory write, ldr and str address
//  reduction ahead of those; an item taken after halt goes straight to
//  writeback. After reset the data memory is swept to zero with in_stall
//  high. A result held by out_stall keeps the block in writeback.
//
module scalar_vector_cpu_execute #(
    parameter int DATA_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  cmd,
    input  logic [7:0]  dest_byte,
    input  logic [7:0]  first_src_byte,
    input  logic [7:0]  second_src_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_pc,
    output logic        halted,
    output logic        div_by_zero,
    output logic        unknown_op,
    output logic        flag_zero,
    output logic        flag_negative,
    output logic        flag_carry,
    output logic        flag_overflow,
    output logic signed [31:0] written_value
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [31:0] DIVISOR = 32'(DATA_WORDS);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(DATA_WORDS));
    localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_WORDS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RA, S_RB, S_RC, S_EXEC, S_LANE, S_DIV,
        S_DIVEND, S_MOD, S_MEMRD, S_MEMWAIT, S_MEMWR, S_WB
    } state_t;

    state_t state_reg;

    logic [7:0] op_reg, d_reg, s1_reg, s2_reg;
    svce_pkg::word_t a_reg, b_reg, res_reg, quo_reg, rem_reg, dvs_reg;
    svce_pkg::vec_t  va_reg, vb_reg, vres_reg;
    logic [1:0]  lane_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg, wr_reg, dz_reg, unk_reg, halt_reg;
    logic [3:0]  flags_reg;
    logic [15:0] pc_reg, npc_reg;
    logic [AW-1:0] addr_reg, clr_reg;
    logic [svce_pkg::SCALAR_NUM-1:0] svalid_reg;
    logic [svce_pkg::VECTOR_NUM-1:0] vvalid_reg;

    logic        out_valid_reg, o_halt_reg, o_dz_reg, o_unk_reg;
    logic [15:0] o_pc_reg;
    logic [3:0]  o_flags_reg;
    svce_pkg::word_t o_wval_reg;

    // memories
    svce_pkg::word_t smem [svce_pkg::SCALAR_NUM];
    svce_pkg::vec_t  vmem [svce_pkg::VECTOR_NUM];
    svce_pkg::word_t dmem [DATA_WORDS];
    svce_pkg::word_t srd_reg, drd_reg;
    svce_pkg::vec_t  vrd_reg;
    logic            sval_reg, vval_reg;

    logic [7:0]      s_raddr;
    logic [4:0]      v_raddr;
    logic            wb_go, sw_en, vw_en, dw_en;
    svce_pkg::vec_t  vw_data;
    logic [AW-1:0]   dw_addr;
    svce_pkg::word_t dw_data;

    // shared unit
    svce_pkg::word_t alu_x, alu_y, alu_r, prod, rem_sh, a_mag, b_mag, lane_a;
    logic            alu_sub;
    logic [32:0]     sum;
    logic            add_c, add_v, sub_c, sub_v, cond_ok;
    logic [3:0]      cc;
    logic [15:0]     br_target;

    // data address reduction
    logic [63:0]     recip_prod;
    svce_pkg::word_t rem_fix;

    assign in_stall = (state_reg != S_IDLE);
    assign wb_go    = (state_reg == S_WB) && (!out_valid_reg || !out_stall);

    assign s_raddr = (state_reg == S_RA) ? s1_reg
                   : ((op_reg == svce_pkg::OP_STR) ? d_reg : s2_reg);
    assign v_raddr = (state_reg == S_RA) ? s1_reg[4:0] : s2_reg[4:0];

    assign rem_sh = {rem_reg[30:0], quo_reg[31]};
    assign lane_a = va_reg[lane_reg*32 +: 32];

    always_comb
    begin
        alu_x   = a_reg;
        alu_y   = b_reg;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_LANE:
            begin
                alu_x   = lane_a;
                alu_y   = vb_reg[lane_reg*32 +: 32];
                alu_sub = (op_reg == svce_pkg::OP_VSUB);
            end
            S_DIV:
            begin
                alu_x   = rem_sh;
                alu_y   = dvs_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                if (op_reg == svce_pkg::OP_ADDI || op_reg == svce_pkg::OP_SUBI
                    || op_reg == svce_pkg::OP_MULI)
                begin
                    alu_y = 32'(s2_reg);
                end
                alu_sub = (op_reg == svce_pkg::OP_SUB) || (op_reg == svce_pkg::OP_SUBI);
            end
        endcase
    end

    assign sum   = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + 33'(alu_sub);
    assign alu_r = sum[31:0];
    assign prod  = alu_x * alu_y;
    assign add_c = sum[32];
    assign add_v = (alu_x[31] == alu_y[31]) && (alu_r[31] != alu_x[31]);
    assign sub_c = sum[32] && (alu_r != '0);
    assign sub_v = (alu_x[31] != alu_y[31]) && (alu_r[31] == alu_y[31]);

    assign a_mag = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign b_mag = b_reg[31] ? (32'd0 - b_reg) : b_reg;

    assign recip_prod = 64'(b_reg) * 64'(RECIP);
    assign rem_fix    = (rem_reg >= DIVISOR) ? (rem_reg - DIVISOR) : rem_reg;

    assign cc = 4'(op_reg - svce_pkg::OP_BR_LO);
    always_comb
    begin
        unique case (cc)
            svce_pkg::CC_EQ: cond_ok = flags_reg[svce_pkg::FLAG_Z];
            svce_pkg::CC_NE: cond_ok = !flags_reg[svce_pkg::FLAG_Z];
            svce_pkg::CC_CS: cond_ok = flags_reg[svce_pkg::FLAG_C];
            svce_pkg::CC_CC: cond_ok = !flags_reg[svce_pkg::FLAG_C];
            svce_pkg::CC_MI: cond_ok = flags_reg[svce_pkg::FLAG_N];
            svce_pkg::CC_PL: cond_ok = !flags_reg[svce_pkg::FLAG_N];
            svce_pkg::CC_VS: cond_ok = flags_reg[svce_pkg::FLAG_V];
            svce_pkg::CC_VC: cond_ok = !flags_reg[svce_pkg::FLAG_V];
            svce_pkg::CC_HI: cond_ok = flags_reg[svce_pkg::FLAG_C]
                                       && !flags_reg[svce_pkg::FLAG_Z];
            svce_pkg::CC_LS: cond_ok = !flags_reg[svce_pkg::FLAG_C]
                                       || flags_reg[svce_pkg::FLAG_Z];
            svce_pkg::CC_GE: cond_ok = flags_reg[svce_pkg::FLAG_N]
                                       == flags_reg[svce_pkg::FLAG_V];
            svce_pkg::CC_LT: cond_ok = flags_reg[svce_pkg::FLAG_N]
                                       != flags_reg[svce_pkg::FLAG_V];
            svce_pkg::CC_GT: cond_ok = !flags_reg[svce_pkg::FLAG_Z]
                                       && (flags_reg[svce_pkg::FLAG_N]
                                           == flags_reg[svce_pkg::FLAG_V]);
            svce_pkg::CC_LE: cond_ok = flags_reg[svce_pkg::FLAG_Z]
                                       || (flags_reg[svce_pkg::FLAG_N]
                                           != flags_reg[svce_pkg::FLAG_V]);
            default:         cond_ok = 1'b1;
        endcase
    end

    assign br_target = pc_reg + {{6{s2_reg[7]}}, s2_reg, 2'b00};

    assign sw_en = wb_go && wr_reg;

    always_comb
    begin
        vw_en   = 1'b0;
        vw_data = vres_reg;
        if (state_reg == S_EXEC && op_reg == svce_pkg::OP_VBCAST)
        begin
            vw_en   = 1'b1;
            vw_data = {svce_pkg::LANES{32'(s1_reg)}};
        end
        else if (state_reg == S_LANE && lane_reg == 2'd3)
        begin
            vw_en   = 1'b1;
            vw_data = {(op_reg == svce_pkg::OP_VMUL) ? prod : alu_r, vres_reg[95:0]};
        end
    end

    always_comb
    begin
        dw_en   = 1'b0;
        dw_addr = addr_reg;
        dw_data = a_reg;
        if (state_reg == S_CLEAR)
        begin
            dw_en   = 1'b1;
            dw_addr = clr_reg;
            dw_data = '0;
        end
        else if (state_reg == S_MEMWR)
        begin
            dw_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        srd_reg <= smem[s_raddr];
        if (sw_en)
        begin
            smem[d_reg] <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vrd_reg <= vmem[v_raddr];
        if (vw_en)
        begin
            vmem[d_reg[4:0]] <= vw_data;
        end
    end

    always_ff @(posedge clk)
    begin
        drd_reg <= dmem[addr_reg];
        if (dw_en)
        begin
            dmem[dw_addr] <= dw_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            svalid_reg    <= '0;
            vvalid_reg    <= '0;
            sval_reg      <= 1'b0;
            vval_reg      <= 1'b0;
            flags_reg     <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            o_halt_reg    <= 1'b0;
            o_dz_reg      <= 1'b0;
            o_unk_reg     <= 1'b0;
            o_pc_reg      <= '0;
            o_flags_reg   <= '0;
            o_wval_reg    <= '0;
            wr_reg        <= 1'b0;
            dz_reg        <= 1'b0;
            unk_reg       <= 1'b0;
        end
        else
        begin
            sval_reg <= svalid_reg[s_raddr];
            vval_reg <= vvalid_reg[v_raddr];
            if (out_valid_reg && !out_stall && !wb_go)
            begin
                out_valid_reg <= 1'b0;
            end
            if (vw_en)
            begin
                vvalid_reg[d_reg[4:0]] <= 1'b1;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg  <= cmd;
                        d_reg   <= dest_byte;
                        s1_reg  <= first_src_byte;
                        s2_reg  <= second_src_byte;
                        wr_reg  <= 1'b0;
                        dz_reg  <= 1'b0;
                        unk_reg <= 1'b0;
                        res_reg <= '0;
                        if (halt_reg)
                        begin
                            npc_reg   <= pc_reg;
                            state_reg <= S_WB;
                        end
                        else
                        begin
                            npc_reg   <= pc_reg + 16'd4;
                            state_reg <= S_RA;
                        end
                    end
                end
                S_RA:
                begin
                    state_reg <= S_RB;
                end
                S_RB:
                begin
                    a_reg     <= sval_reg ? srd_reg : '0;
                    va_reg    <= vval_reg ? vrd_reg : '0;
                    state_reg <= S_RC;
                end
                S_RC:
                begin
                    b_reg     <= sval_reg ? srd_reg : '0;
                    vb_reg    <= vval_reg ? vrd_reg : '0;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    lane_reg  <= '0;
                    if (op_reg == svce_pkg::OP_ADD || op_reg == svce_pkg::OP_ADDI)
                    begin
                        res_reg   <= alu_r;
                        wr_reg    <= 1'b1;
                        flags_reg <= {add_v, add_c, alu_r[31], alu_r == '0};
                        state_reg <= S_WB;
                    end
                    else if (op_reg == svce_pkg::OP_SUB || op_reg == svce_pkg::OP_SUBI)
                    begin
                        res_reg   <= alu_r;
                        wr_reg    <= 1'b1;
                        flags_reg <= {sub_v, sub_c, alu_r[31], alu_r == '0};
                        state_reg <= S_WB;
                    end
                    else if (op_reg == svce_pkg::OP_MUL || op_reg == svce_pkg::OP_MULI)
                    begin
                        res_reg   <= prod;
                        wr_reg    <= 1'b1;
                        state_reg <= S_WB;
                    end
                    else if (op_reg == svce_pkg::OP_DIV)
                    begin
                        if (b_reg == '0)
                        begin
                            dz_reg    <= 1'b1;
                            state_reg <= S_WB;
                        end
                        else
                        begin
                            quo_reg   <= a_mag;
                            dvs_reg   <= b_mag;
                            neg_reg   <= a_reg[31] ^ b_reg[31];
                            state_reg <= S_DIV;
                        end
                    end
                    else if (op_reg == svce_pkg::OP_DIVI)
                    begin
                        if (s2_reg == '0)
                        begin
                            dz_reg    <= 1'b1;
                            state_reg <= S_WB;
                        end
                        else
                        begin
                            quo_reg   <= a_mag;
                            dvs_reg   <= 32'(s2_reg);
                            neg_reg   <= a_reg[31];
                            state_reg <= S_DIV;
                        end
                    end
                    else if (op_reg == svce_pkg::OP_LDR || op_reg == svce_pkg::OP_STR)
                    begin
                        quo_reg   <= recip_prod[63:32];
                        state_reg <= S_MOD;
                    end
                    else if (op_reg == svce_pkg::OP_LDI)
                    begin
                        addr_reg  <= AW'(s2_reg);
                        state_reg <= S_MEMRD;
                    end
                    else if (op_reg == svce_pkg::OP_STI)
                    begin
                        addr_reg  <= AW'(d_reg);
                        state_reg <= S_MEMWR;
                    end
                    else if (op_reg == svce_pkg::OP_MOVI)
                    begin
                        res_reg   <= 32'(s1_reg);
                        wr_reg    <= 1'b1;
                        state_reg <= S_WB;
                    end
                    else if (op_reg == svce_pkg::OP_MOV)
                    begin
                        res_reg   <= a_reg;
                        wr_reg    <= 1'b1;
                        state_reg <= S_WB;
                    end
                    else if (op_reg == svce_pkg::OP_VADD || op_reg == svce_pkg::OP_VSUB
                             || op_reg == svce_pkg::OP_VMUL)
                    begin
                        state_reg <= S_LANE;
                    end
                    else if (op_reg == svce_pkg::OP_VEXT)
                    begin
                        res_reg   <= va_reg[s2_reg[1:0]*32 +: 32];
                        wr_reg    <= 1'b1;
                        state_reg <= S_WB;
                    end
                    else if (op_reg == svce_pkg::OP_HALT)
                    begin
                        halt_reg  <= 1'b1;
                        state_reg <= S_WB;
                    end
                    else if (op_reg >= svce_pkg::OP_BR_LO && op_reg <= svce_pkg::OP_BR_HI)
                    begin
                        if (cond_ok)
                        begin
                            npc_reg <= br_target;
                        end
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        state_reg <= S_WB;
                        if (op_reg != svce_pkg::OP_VBCAST)
                        begin
                            unk_reg  <= 1'b1;
                            halt_reg <= 1'b1;
                        end
                    end
                end
                S_LANE:
                begin
                    vres_reg[lane_reg*32 +: 32] <=
                        (op_reg == svce_pkg::OP_VMUL) ? prod : alu_r;
                    lane_reg <= lane_reg + 1'b1;
                    if (lane_reg == 2'd3)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= sum[32] ? alu_r : rem_sh;
                    quo_reg <= {quo_reg[30:0], sum[32]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_DIVEND;
                    end
                end
                S_MOD:
                begin
                    rem_reg   <= b_reg - quo_reg * DIVISOR;
                    state_reg <= S_DIVEND;
                end
                S_DIVEND:
                begin
                    if (op_reg == svce_pkg::OP_DIV || op_reg == svce_pkg::OP_DIVI)
                    begin
                        res_reg   <= neg_reg ? (32'd0 - quo_reg) : quo_reg;
                        wr_reg    <= 1'b1;
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        addr_reg  <= rem_fix[AW-1:0];
                        state_reg <= (op_reg == svce_pkg::OP_LDR) ? S_MEMRD : S_MEMWR;
                    end
                end
                S_MEMRD:
                begin
                    state_reg <= S_MEMWAIT;
                end
                S_MEMWAIT:
                begin
                    res_reg   <= drd_reg;
                    wr_reg    <= 1'b1;
                    state_reg <= S_WB;
                end
                S_MEMWR:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (wb_go)
                    begin
                        pc_reg        <= npc_reg;
                        out_valid_reg <= 1'b1;
                        o_pc_reg      <= npc_reg;
                        o_halt_reg    <= halt_reg;
                        o_dz_reg      <= dz_reg;
                        o_unk_reg     <= unk_reg;
                        o_flags_reg   <= flags_reg;
                        o_wval_reg    <= wr_reg ? res_reg : '0;
                        if (wr_reg)
                        begin
                            svalid_reg[d_reg] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_pc       = o_pc_reg;
    assign halted        = o_halt_reg;
    assign div_by_zero   = o_dz_reg;
    assign unknown_op    = o_unk_reg;
    assign flag_zero     = o_flags_reg[svce_pkg::FLAG_Z];
    assign flag_negative = o_flags_reg[svce_pkg::FLAG_N];
    assign flag_carry    = o_flags_reg[svce_pkg::FLAG_C];
    assign flag_overflow = o_flags_reg[svce_pkg::FLAG_V];
    assign written_value = o_wval_reg;

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt mark cleared without reset");

    a_dz_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> written_value == '0)
        else $error("zero divisor reported with a written value");

    a_unk_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unknown_op |-> halted)
        else $error("unknown opcode without halt");

    a_pc_at_wb: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(pc_reg) |-> $past(state_reg == S_WB))
        else $error("program counter moved outside writeback");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        wb_go |=> out_valid && state_reg == S_IDLE)
        else $error("writeback did not present a result");
`endif

endmodule

// ===== tb/scalar_vector_cpu_execute_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_vector_cpu_execute_tb - instruction-level check of the execute stage
// Drives directed and random instruction streams with random idling on both
// channels and compares each result against a behavioural processor model.
// ----------------------------------------------------------------------------
module scalar_vector_cpu_execute_tb;

    localparam int DW    = 1024;
    localparam int LIMIT = 20000;

    typedef struct packed {
        logic [15:0] pc;
        logic        hlt;
        logic        dz;
        logic        unk;
        logic [3:0]  fl;
        logic [31:0] wv;
    } outcome_t;

    class exec_scoreboard;
        svce_pkg::word_t sreg [svce_pkg::SCALAR_NUM];
        svce_pkg::word_t vreg [svce_pkg::VECTOR_NUM][svce_pkg::LANES];
        svce_pkg::word_t dmem [DW];
        logic [15:0] pc;
        logic [3:0]  fl;
        logic        hlt;
        outcome_t    pending [$];
        int          errors;

        function void clear();
            foreach (sreg[i]) sreg[i] = '0;
            foreach (vreg[i, k]) vreg[i][k] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            pc = '0;
            fl = '0;
            hlt = 1'b0;
            errors = 0;
        endfunction

        function svce_pkg::word_t add_set(svce_pkg::word_t a, svce_pkg::word_t b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            fl[svce_pkg::FLAG_Z] = (s[31:0] == 0);
            fl[svce_pkg::FLAG_N] = s[31];
            fl[svce_pkg::FLAG_C] = s[32];
            fl[svce_pkg::FLAG_V] = (a[31] == b[31]) && (s[31] != a[31]);
            return s[31:0];
        endfunction

        function svce_pkg::word_t sub_set(svce_pkg::word_t a, svce_pkg::word_t b);
            svce_pkg::word_t r;
            r = a - b;
            fl[svce_pkg::FLAG_Z] = (r == 0);
            fl[svce_pkg::FLAG_N] = r[31];
            fl[svce_pkg::FLAG_C] = a > b;
            fl[svce_pkg::FLAG_V] = (a[31] != b[31]) && (r[31] == b[31]);
            return r;
        endfunction

        function svce_pkg::word_t quot(svce_pkg::word_t a, svce_pkg::word_t b);
            svce_pkg::word_t ua, ub, q;
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q = ua / ub;
            return (a[31] ^ b[31]) ? -q : q;
        endfunction

        function logic cond_met(logic [3:0] c);
            logic z, n, cy, v;
            z = fl[svce_pkg::FLAG_Z];
            n = fl[svce_pkg::FLAG_N];
            cy = fl[svce_pkg::FLAG_C];
            v = fl[svce_pkg::FLAG_V];
            case (c)
                svce_pkg::CC_EQ: return z;
                svce_pkg::CC_NE: return !z;
                svce_pkg::CC_CS: return cy;
                svce_pkg::CC_CC: return !cy;
                svce_pkg::CC_MI: return n;
                svce_pkg::CC_PL: return !n;
                svce_pkg::CC_VS: return v;
                svce_pkg::CC_VC: return !v;
                svce_pkg::CC_HI: return cy && !z;
                svce_pkg::CC_LS: return !cy || z;
                svce_pkg::CC_GE: return n == v;
                svce_pkg::CC_LT: return n != v;
                svce_pkg::CC_GT: return !z && n == v;
                svce_pkg::CC_LE: return z || n != v;
                default: return 1'b1;
            endcase
        endfunction

        function void note_instr(logic [7:0] op, logic [7:0] d, logic [7:0] s1,
                                 logic [7:0] s2);
            outcome_t o;
            svce_pkg::word_t r;
            logic wr;
            logic [15:0] nxt;
            o = '0;
            r = '0;
            wr = 1'b0;
            if (!hlt) begin
                nxt = pc + 16'd4;
                case (op)
                    svce_pkg::OP_ADD:  begin r = add_set(sreg[s1], sreg[s2]); wr = 1; end
                    svce_pkg::OP_SUB:  begin r = sub_set(sreg[s1], sreg[s2]); wr = 1; end
                    svce_pkg::OP_ADDI: begin r = add_set(sreg[s1], {24'd0, s2}); wr = 1; end
                    svce_pkg::OP_SUBI: begin r = sub_set(sreg[s1], {24'd0, s2}); wr = 1; end
                    svce_pkg::OP_MUL:  begin r = sreg[s1] * sreg[s2]; wr = 1; end
                    svce_pkg::OP_MULI: begin r = sreg[s1] * {24'd0, s2}; wr = 1; end
                    svce_pkg::OP_DIV:
                        if (sreg[s2] == 0) o.dz = 1;
                        else begin r = quot(sreg[s1], sreg[s2]); wr = 1; end
                    svce_pkg::OP_DIVI:
                        if (s2 == 0) o.dz = 1;
                        else begin r = quot(sreg[s1], {24'd0, s2}); wr = 1; end
                    svce_pkg::OP_LDR:  begin r = dmem[sreg[s2] % DW]; wr = 1; end
                    svce_pkg::OP_LDI:  begin r = dmem[s2 % DW]; wr = 1; end
                    svce_pkg::OP_STR:  dmem[sreg[d] % DW] = sreg[s1];
                    svce_pkg::OP_STI:  dmem[d % DW] = sreg[s1];
                    svce_pkg::OP_MOVI: begin r = {24'd0, s1}; wr = 1; end
                    svce_pkg::OP_MOV:  begin r = sreg[s1]; wr = 1; end
                    svce_pkg::OP_VBCAST: for (int k = 0; k < svce_pkg::LANES; k++)
                        vreg[d[4:0]][k] = {24'd0, s1};
                    svce_pkg::OP_VADD: for (int k = 0; k < svce_pkg::LANES; k++)
                        vreg[d[4:0]][k] = vreg[s1[4:0]][k] + vreg[s2[4:0]][k];
                    svce_pkg::OP_VSUB: for (int k = 0; k < svce_pkg::LANES; k++)
                        vreg[d[4:0]][k] = vreg[s1[4:0]][k] - vreg[s2[4:0]][k];
                    svce_pkg::OP_VMUL: for (int k = 0; k < svce_pkg::LANES; k++)
                        vreg[d[4:0]][k] = vreg[s1[4:0]][k] * vreg[s2[4:0]][k];
                    svce_pkg::OP_VEXT: begin r = vreg[s1[4:0]][s2[1:0]]; wr = 1; end
                    svce_pkg::OP_HALT: hlt = 1;
                    default:
                        if (op >= svce_pkg::OP_BR_LO && op <= svce_pkg::OP_BR_HI) begin
                            if (cond_met(4'(op - svce_pkg::OP_BR_LO)))
                                nxt = pc + 16'({{8{s2[7]}}, s2} << 2);
                        end else begin
                            o.unk = 1;
                            hlt = 1;
                        end
                endcase
                if (wr) begin
                    sreg[d] = r;
                    o.wv = r;
                end
                pc = nxt;
            end
            o.pc = pc;
            o.hlt = hlt;
            o.fl = fl;
            pending.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t e;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing pending: %h", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.pc !== e.pc)
                $display("%0t: next_pc exp %h got %h", $realtime, e.pc, got.pc);
            if (got.hlt !== e.hlt)
                $display("%0t: halted exp %b got %b", $realtime, e.hlt, got.hlt);
            if (got.dz !== e.dz)
                $display("%0t: div_by_zero exp %b got %b", $realtime, e.dz, got.dz);
            if (got.unk !== e.unk)
                $display("%0t: unknown_op exp %b got %b", $realtime, e.unk, got.unk);
            if (got.fl !== e.fl)
                $display("%0t: flags exp %b got %b", $realtime, e.fl, got.fl);
            if (got.wv !== e.wv)
                $display("%0t: written_value exp %h got %h", $realtime, e.wv, got.wv);
            if (got !== e) errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  cmd;
    logic [7:0]  dest_byte;
    logic [7:0]  first_src_byte;
    logic [7:0]  second_src_byte;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] next_pc;
    logic        halted;
    logic        div_by_zero;
    logic        unknown_op;
    logic        flag_zero;
    logic        flag_negative;
    logic        flag_carry;
    logic        flag_overflow;
    logic signed [31:0] written_value;

    exec_scoreboard sb;
    logic quiet;
    logic hold_long;
    logic done;
    int   idle_cycles;
    int   settle;
    int   stall_left;

    scalar_vector_cpu_execute #(.DATA_WORDS(DW)) u_dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic issue(logic [7:0] op, logic [7:0] d, logic [7:0] s1,
                         logic [7:0] s2);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= op;
        dest_byte       <= d;
        first_src_byte  <= s1;
        second_src_byte <= s2;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_instr(op, d, s1, s2);
    endtask

    task automatic random_instr();
        logic [7:0] op, d, s1, s2;
        int pick;
        pick = $urandom_range(0, 99);
        d  = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        s1 = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        s2 = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        if (pick < 12) op = svce_pkg::OP_MOVI;
        else if (pick < 20) op = svce_pkg::OP_BR_LO + 8'($urandom_range(0, 14));
        else if (pick < 23) op = svce_pkg::OP_DIV + 8'($urandom_range(0, 1));
        else op = 8'($urandom_range(0, 18));
        if (op == svce_pkg::OP_DIV || op == svce_pkg::OP_DIVI
            || op == svce_pkg::OP_LDR || op == svce_pkg::OP_STR)
            if ($urandom_range(0, 1)) op = svce_pkg::OP_ADD + 8'($urandom_range(0, 5));
        issue(op, d, s1, s2);
    endtask

    task automatic reset_dut();
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (hold_long) begin
            out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 16);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({next_pc, halted, div_by_zero, unknown_op, flag_overflow,
                             flag_carry, flag_negative, flag_zero,
                             32'(written_value)});
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT + DW) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        hold_long = 1'b0;
        #2000;
        @(posedge clk);
        hold_long = 1'b1;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
    end

    initial begin
        sb = new();
        sb.clear();
        quiet = 1'b0;
        done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = '0;
        dest_byte = '0;
        first_src_byte = '0;
        second_src_byte = '0;
        reset_dut();
        // directed: extremes, flags, division corners, loads and stores, vectors, branches
        issue(svce_pkg::OP_MOVI, 8'd1, 8'hFF, 8'd0);
        issue(svce_pkg::OP_SUBI, 8'd2, 8'd0, 8'd1);
        issue(svce_pkg::OP_ADD, 8'd3, 8'd2, 8'd2);
        issue(svce_pkg::OP_ADDI, 8'd4, 8'd2, 8'd1);
        issue(svce_pkg::OP_MULI, 8'd5, 8'd1, 8'hFF);
        issue(svce_pkg::OP_MUL, 8'd6, 8'd5, 8'd5);
        issue(svce_pkg::OP_SUB, 8'd7, 8'd0, 8'd1);
        issue(svce_pkg::OP_DIV, 8'd8, 8'd1, 8'd0);
        issue(svce_pkg::OP_DIVI, 8'd9, 8'd2, 8'd0);
        issue(svce_pkg::OP_DIVI, 8'd9, 8'd2, 8'd3);
        issue(svce_pkg::OP_BR_LO + 8'd14, 8'd0, 8'd0, 8'h01);
        issue(svce_pkg::OP_MOV, 8'd255, 8'd6, 8'd0);
        issue(svce_pkg::OP_STR, 8'd2, 8'd1, 8'd0);
        issue(svce_pkg::OP_STI, 8'd255, 8'd255, 8'd0);
        issue(svce_pkg::OP_LDR, 8'd10, 8'd0, 8'd2);
        issue(svce_pkg::OP_LDI, 8'd11, 8'd0, 8'd255);
        issue(svce_pkg::OP_VBCAST, 8'hFF, 8'hFF, 8'd0);
        issue(svce_pkg::OP_VADD, 8'd1, 8'd31, 8'hFF);
        issue(svce_pkg::OP_VSUB, 8'd2, 8'd0, 8'd1);
        issue(svce_pkg::OP_VMUL, 8'd3, 8'd2, 8'd2);
        issue(svce_pkg::OP_VEXT, 8'd12, 8'd3, 8'hFF);
        issue(svce_pkg::OP_BR_LO + 8'd1, 8'd0, 8'd0, 8'h80);
        issue(svce_pkg::OP_BR_LO, 8'd0, 8'd0, 8'h7F);
        for (int i = 0; i < 750; i++) begin
            if (i == 700) quiet = 1'b1;
            random_instr();
        end
        // halt, then items that must be ignored
        issue(svce_pkg::OP_HALT, 8'd0, 8'd0, 8'd0);
        issue(svce_pkg::OP_MOVI, 8'd1, 8'd5, 8'd0);
        issue(8'hFF, 8'd0, 8'd0, 8'd0);
        in_valid <= 1'b0;
        settle = 0;
        while (sb.pending.size() != 0 && settle < LIMIT) begin
            @(posedge clk);
            settle++;
        end
        repeat (60) @(posedge clk);
        done = 1'b1;
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
